@@ rtl/ttu_pkg.sv @@
// ttu_pkg: shared types and constants for the text-to-unsigned parser
// holds the parse phase enum, the queued item struct and the character codes
// no dependencies
`default_nettype none

package ttu_pkg;

   localparam int RADIX_BITS  = 6;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // character codes
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;
   localparam logic [7:0] LETTER_BASE  = 8'd10;

   // radix codes
   localparam logic [RADIX_BITS-1:0] BASE_DETECT = 6'd0;
   localparam logic [RADIX_BITS-1:0] BASE_OCT    = 6'd8;
   localparam logic [RADIX_BITS-1:0] BASE_DEC    = 6'd10;
   localparam logic [RADIX_BITS-1:0] BASE_HEX    = 6'd16;

   // register index of the radix register
   localparam logic REG_RADIX = 1'b0;

   typedef enum logic [2:0] {
      PH_DONE,
      PH_SPACE,
      PH_ZERO0,
      PH_ZERO16,
      PH_DIGITS
   } phase_type;

   // one classified byte
   typedef struct packed {
      logic                  first;
      logic                  blank;
      logic                  zero;
      logic                  lower_x;
      logic                  alnum;
      logic [RADIX_BITS-1:0] dval;
      logic [RADIX_BITS-1:0] radix;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_port_type;

endpackage

`default_nettype wire

@@ rtl/ttu_front.sv @@
// ttu_front: accepts input bytes and classifies them for the back end
// depends on ttu_pkg
`default_nettype none

module ttu_front (
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [7:0]                     req_ch,
   input  wire logic                           req_first,
   input  wire logic [ttu_pkg::RADIX_BITS-1:0] radix,
   input  wire logic                           queue_full,
   output ttu_pkg::queue_port_type             push
);
   import ttu_pkg::*;

   item_type item;

   always_comb begin
      item         = '0;
      item.first   = req_first;
      item.radix   = radix;
      item.blank   = (req_ch == CHAR_SPACE) || (req_ch >= CHAR_TAB && req_ch <= CHAR_CR);
      item.zero    = (req_ch == CHAR_ZERO);
      item.lower_x = (req_ch == CHAR_LOWER_X);
      priority if (req_ch >= CHAR_ZERO && req_ch <= CHAR_NINE) begin
         item.alnum = 1'b1;
         item.dval  = RADIX_BITS'(req_ch - CHAR_ZERO);
      end else if (req_ch >= CHAR_UPPER_A && req_ch <= CHAR_UPPER_Z) begin
         item.alnum = 1'b1;
         item.dval  = RADIX_BITS'(req_ch - CHAR_UPPER_A + LETTER_BASE);
      end else if (req_ch >= CHAR_LOWER_A && req_ch <= CHAR_LOWER_Z) begin
         item.alnum = 1'b1;
         item.dval  = RADIX_BITS'(req_ch - CHAR_LOWER_A + LETTER_BASE);
      end else begin
         item.alnum = 1'b0;
         item.dval  = '0;
      end
   end

   assign req_stall  = queue_full;
   assign push.valid = req_valid & ~queue_full;
   assign push.item  = item;

endmodule

`default_nettype wire

@@ rtl/ttu_queue.sv @@
// ttu_queue: small register queue of classified items between front and back
// depends on ttu_pkg
`default_nettype none

module ttu_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ttu_pkg::queue_port_type push,
   output logic                         full,
   output ttu_pkg::queue_port_type      head,
   input  wire logic                    pop
);
   import ttu_pkg::*;

   item_type               entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full       = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.item  = entries_ff[rd_ptr_ff];

   assign do_push = push.valid & ~full;
   assign do_pop  = pop & head.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

`default_nettype wire

@@ rtl/ttu_back.sv @@
// ttu_back: parse state machine, multiply-add accumulator and result register
// depends on ttu_pkg
`default_nettype none

module ttu_back #(
   parameter int VALUE_BITS  = 32,
   parameter int OFFSET_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ttu_pkg::queue_port_type head,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [VALUE_BITS-1:0]        rsp_value,
   output logic [OFFSET_BITS-1:0]       rsp_end_offset,
   output logic                         rsp_found_digits
);
   import ttu_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [VALUE_BITS-1:0]  acc_ff, acc_in;
   logic [OFFSET_BITS-1:0] count_ff, count_in;
   logic                   seen_ff, seen_in;
   logic [RADIX_BITS-1:0]  base_ff, base_in;

   logic                   out_valid_ff, out_valid_in;
   logic [VALUE_BITS-1:0]  out_value_ff, out_value_in;
   logic [OFFSET_BITS-1:0] out_offset_ff, out_offset_in;
   logic                   out_found_ff, out_found_in;

   phase_type              cur_phase;
   logic [VALUE_BITS-1:0]  cur_acc;
   logic [OFFSET_BITS-1:0] cur_count, count_inc;
   logic                   cur_seen;
   logic [RADIX_BITS-1:0]  cur_base;
   logic                   do_step;
   logic                   take;
   logic                   emit;
   item_type               it;

   // a result may be loaded whenever the output register is free or drains now
   assign pop = head.valid & (~out_valid_ff | ~rsp_stall);
   assign it  = head.item;

   always_comb begin
      // a first byte restarts the parse with the current radix
      cur_phase = it.first ? PH_SPACE : phase_ff;
      cur_acc   = it.first ? '0 : acc_ff;
      cur_count = it.first ? '0 : count_ff;
      cur_seen  = it.first ? 1'b0 : seen_ff;
      cur_base  = it.first ? it.radix : base_ff;
      count_inc = (&cur_count) ? cur_count : cur_count + OFFSET_BITS'(1);

      phase_in = cur_phase;
      acc_in   = cur_acc;
      count_in = cur_count;
      seen_in  = cur_seen;
      base_in  = cur_base;
      do_step  = 1'b0;

      unique case (cur_phase)
         PH_SPACE: begin
            if (it.blank) begin
               count_in = count_inc;
            end else if (cur_base == BASE_DETECT) begin
               if (it.zero) begin
                  count_in = count_inc;
                  phase_in = PH_ZERO0;
               end else begin
                  base_in = BASE_DEC;
                  do_step = 1'b1;
               end
            end else if (cur_base == BASE_HEX && it.zero) begin
               seen_in  = 1'b1;
               count_in = count_inc;
               phase_in = PH_ZERO16;
            end else begin
               do_step = 1'b1;
            end
         end
         PH_ZERO0: begin
            if (it.lower_x) begin
               base_in  = BASE_HEX;
               count_in = count_inc;
               phase_in = PH_DIGITS;
            end else begin
               // the leading zero was an octal digit
               base_in = BASE_OCT;
               seen_in = 1'b1;
               do_step = 1'b1;
            end
         end
         PH_ZERO16: begin
            if (it.lower_x) begin
               // prefix alone does not count as digits
               seen_in  = 1'b0;
               count_in = count_inc;
               phase_in = PH_DIGITS;
            end else begin
               do_step = 1'b1;
            end
         end
         PH_DIGITS: begin
            do_step = 1'b1;
         end
         default: begin
            do_step = 1'b0;
         end
      endcase

      take = do_step & it.alnum & (it.dval < base_in);
      emit = do_step & ~take;

      if (take) begin
         acc_in   = VALUE_BITS'(cur_acc * VALUE_BITS'(base_in)) + VALUE_BITS'(it.dval);
         seen_in  = 1'b1;
         count_in = count_inc;
         phase_in = PH_DIGITS;
      end else if (emit) begin
         phase_in = PH_DONE;
      end

      out_value_in  = acc_in;
      out_offset_in = seen_in ? count_in : '0;
      out_found_in  = seen_in;

      if (pop && emit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DONE;
         acc_ff       <= '0;
         count_ff     <= '0;
         seen_ff      <= 1'b0;
         base_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            count_ff <= count_in;
            seen_ff  <= seen_in;
            base_ff  <= base_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         out_value_ff  <= out_value_in;
         out_offset_ff <= out_offset_in;
         out_found_ff  <= out_found_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_value        = out_value_ff;
   assign rsp_end_offset   = out_offset_ff;
   assign rsp_found_digits = out_found_ff;

endmodule

`default_nettype wire

@@ rtl/text_to_unsigned_parser.sv @@
// text_to_unsigned_parser: streaming text to unsigned integer parser, top level
// depends on ttu_pkg, ttu_front, ttu_queue and ttu_back
//
//   port group  direction  contents
//   req_        in         ch, first; handshake valid / stall
//   rsp_        out        value, end_offset, found_digits; handshake valid / stall
//   csr_        in / out   apb-style port, radix register at byte address 0
//
// one byte per cycle sustained while rsp_stall is low; the back end does at most one multiply-add per byte
// after its stop byte is accepted, a result passes through the queue and then the output register
// the front stalls only when the four-entry queue is full
// the back end holds while a finished result waits under rsp_stall
// synchronous reset clears the queue, parse phase, output valid and radix
`default_nettype none

module text_to_unsigned_parser #(
   parameter int VALUE_BITS  = 32,
   parameter int OFFSET_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_ch,
   input  wire logic                   req_first,

   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [VALUE_BITS-1:0]       rsp_value,
   output logic [OFFSET_BITS-1:0]      rsp_end_offset,
   output logic                        rsp_found_digits,

   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [2:0]             csr_paddr,
   input  wire logic [31:0]            csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import ttu_pkg::*;

   logic [RADIX_BITS-1:0] radix_ff, radix_in;
   logic                  csr_write;
   logic                  queue_full;
   logic                  pop;
   queue_port_type        push;
   queue_port_type        head;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign radix_in   = (csr_write && csr_paddr[2] == REG_RADIX) ?
                       csr_pwdata[RADIX_BITS-1:0] : radix_ff;
   assign csr_prdata = (csr_paddr[2] == REG_RADIX) ? 32'(radix_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= BASE_DETECT;
      end else begin
         radix_ff <= radix_in;
      end
   end

   ttu_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_ch     (req_ch),
      .req_first  (req_first),
      .radix      (radix_ff),
      .queue_full (queue_full),
      .push       (push)
   );

   ttu_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   ttu_back #(
      .VALUE_BITS  (VALUE_BITS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value        (rsp_value),
      .rsp_end_offset   (rsp_end_offset),
      .rsp_found_digits (rsp_found_digits)
   );

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// tb_top: self-checking testbench for text_to_unsigned_parser
// sends byte strings, predicts each parsed number on the fly and checks every result
// depends on ttu_pkg and the parser rtl
`timescale 1ns / 1ps

module tb_top;
   import ttu_pkg::*;

   localparam int          NOT_DIGIT     = 100;
   localparam int          QUIET_CYCLES  = 12;
   localparam int          LONG_HOLD     = 200;
   localparam int          STUCK_LIMIT   = 3000;
   localparam logic [2:0]  RADIX_ADDR    = 3'(4 * REG_RADIX);
   localparam logic [15:0] OFFSET_CEIL   = 16'hFFFF;

   typedef struct packed {
      logic [31:0] value;
      logic [15:0] end_offset;
      logic        found_digits;
   } number_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_ch = 8'h00;
   logic        req_first = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_value;
   logic [15:0] rsp_end_offset;
   logic        rsp_found_digits;

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   text_to_unsigned_parser uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ch           (req_ch),
      .req_first        (req_first),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value        (rsp_value),
      .rsp_end_offset   (rsp_end_offset),
      .rsp_found_digits (rsp_found_digits),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #6 clock = ~clock;

   // parser state mirrored by the testbench
   phase_type   scan_phase = PH_DONE;
   logic [31:0] scan_acc   = '0;
   logic [15:0] scan_count = '0;
   logic        scan_seen  = 1'b0;
   logic [5:0]  scan_base  = '0;
   logic [5:0]  cfg_radix  = BASE_DETECT;

   number_type  awaited_numbers[$];
   int          mismatches     = 0;
   int          bytes_sent     = 0;
   int          numbers_seen   = 0;
   int          radix_writes   = 0;
   int          stuck_cycles   = 0;
   int          stall_left     = 0;
   bit          steady         = 1'b0;
   bit          hold_request   = 1'b0;

   function automatic bit is_blank(logic [7:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic int char_digit(logic [7:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return int'(c - CHAR_UPPER_A + LETTER_BASE);
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return int'(c - CHAR_LOWER_A + LETTER_BASE);
      return NOT_DIGIT;
   endfunction

   function automatic void bump_count();
      if (scan_count != OFFSET_CEIL) scan_count = scan_count + 16'd1;
   endfunction

   // advances the mirrored parser by one accepted byte
   function automatic bit parse_byte(input logic [7:0] c, input logic first,
                                     output number_type num);
      bit try_digit;
      int d;
      try_digit = 1'b0;
      num = '0;
      if (first) begin
         scan_acc = '0;
         scan_count = '0;
         scan_seen = 1'b0;
         scan_base = cfg_radix;
         scan_phase = PH_SPACE;
      end
      case (scan_phase)
         PH_SPACE: begin
            if (is_blank(c)) begin
               bump_count();
            end else if (scan_base == BASE_DETECT && c == CHAR_ZERO) begin
               bump_count();
               scan_phase = PH_ZERO0;
            end else if (scan_base == BASE_HEX && c == CHAR_ZERO) begin
               // counts as a digit unless an x follows
               scan_seen = 1'b1;
               bump_count();
               scan_phase = PH_ZERO16;
            end else begin
               if (scan_base == BASE_DETECT) scan_base = BASE_DEC;
               scan_phase = PH_DIGITS;
               try_digit = 1'b1;
            end
         end
         PH_ZERO0: begin
            if (c == CHAR_LOWER_X) begin
               scan_base = BASE_HEX;
               bump_count();
            end else begin
               scan_base = BASE_OCT;
               scan_seen = 1'b1;
               try_digit = 1'b1;
            end
            scan_phase = PH_DIGITS;
         end
         PH_ZERO16: begin
            if (c == CHAR_LOWER_X) begin
               scan_seen = 1'b0;
               bump_count();
            end else begin
               try_digit = 1'b1;
            end
            scan_phase = PH_DIGITS;
         end
         PH_DIGITS: try_digit = 1'b1;
         default: ;
      endcase
      if (!try_digit) return 1'b0;
      d = char_digit(c);
      if (d < int'(scan_base)) begin
         scan_acc = scan_acc * 32'(scan_base) + 32'(d);
         scan_seen = 1'b1;
         bump_count();
         return 1'b0;
      end
      num.value = scan_acc;
      num.end_offset = scan_seen ? scan_count : 16'd0;
      num.found_digits = scan_seen;
      scan_phase = PH_DONE;
      return 1'b1;
   endfunction

   // prediction at the input, comparison at the output, and the progress watchdog
   always @(posedge clock) begin
      number_type fresh, oldest;
      bit moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_valid && !req_stall) begin
            if (parse_byte(req_ch, req_first, fresh)) awaited_numbers.push_back(fresh);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            numbers_seen++;
            if (awaited_numbers.size() == 0) begin
               $display("%0t: unexpected result value %h end_offset %0d found_digits %0d",
                        $time, rsp_value, rsp_end_offset, rsp_found_digits);
               mismatches++;
            end else begin
               oldest = awaited_numbers.pop_front();
               if (rsp_value !== oldest.value) begin
                  $display("%0t: value expected %h actual %h", $time, oldest.value, rsp_value);
                  mismatches++;
               end
               if (rsp_end_offset !== oldest.end_offset) begin
                  $display("%0t: end_offset expected %0d actual %0d",
                           $time, oldest.end_offset, rsp_end_offset);
                  mismatches++;
               end
               if (rsp_found_digits !== oldest.found_digits) begin
                  $display("%0t: found_digits expected %0d actual %0d",
                           $time, oldest.found_digits, rsp_found_digits);
                  mismatches++;
               end
            end
         end
         if (csr_psel) moved = 1'b1;
         stuck_cycles = moved ? 0 : stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, stuck_cycles, awaited_numbers.size());
            $display("status: fail");
            $finish;
         end
      end
   end

   // result side: random stall after each result, or one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = LONG_HOLD;
         end else if (rsp_valid && !rsp_stall && !steady) begin
            stall_left = $urandom_range(0, 3);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // valid is left high after an item; the next call or release_req settles it
   task automatic send_char(input logic [7:0] c, input logic first);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch <= c;
      req_first <= first;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(input string s, input bit start);
      for (int i = 0; i < s.len(); i++) send_char(s[i], start && i == 0);
   endtask

   task automatic release_req();
      req_valid <= 1'b0;
   endtask

   // items without a result may still sit in the queue after the last result
   task automatic settle();
      release_req();
      while (awaited_numbers.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_radix(input logic [5:0] r);
      settle();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= RADIX_ADDR;
      csr_pwdata <= {26'($urandom), r};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      cfg_radix = r;
      radix_writes++;
      // read it back
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[5:0] !== r) begin
         $display("%0t: radix readback expected %0d actual %0d", $time, r, csr_prdata[5:0]);
         mismatches++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [7:0] pick_blank();
      int r;
      r = $urandom_range(0, 5);
      return r == 5 ? CHAR_SPACE : CHAR_TAB + 8'(r);
   endfunction

   function automatic logic [7:0] digit_char(input int d);
      if (d < 10) return CHAR_ZERO + 8'(d);
      return ($urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A) + 8'(d - 10);
   endfunction

   function automatic logic [7:0] pick_stop();
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return CHAR_SPACE;
         2:       return 8'($urandom_range(128, 255));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // mostly well-formed numbers for the current radix, some noise and cut-off strings
   task automatic send_random_string();
      logic [7:0] txt[$];
      int style, b, n, cut;
      style = $urandom_range(0, 9);
      if (style == 0) begin
         n = $urandom_range(1, 6);
         repeat (n) send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         return;
      end
      repeat ($urandom_range(0, 3)) txt.push_back(pick_blank());
      b = int'(cfg_radix);
      if (cfg_radix == BASE_DETECT) begin
         case ($urandom_range(0, 2))
            0: begin
               txt.push_back(CHAR_ZERO);
               txt.push_back(CHAR_LOWER_X);
               b = int'(BASE_HEX);
            end
            1: begin
               txt.push_back(CHAR_ZERO);
               b = int'(BASE_OCT);
            end
            default: begin
               txt.push_back(digit_char($urandom_range(1, 9)));
               b = int'(BASE_DEC);
            end
         endcase
      end else if (cfg_radix == BASE_HEX && $urandom_range(0, 1)) begin
         txt.push_back(CHAR_ZERO);
         txt.push_back(CHAR_LOWER_X);
      end
      n = $urandom_range(0, 11);
      repeat (n) txt.push_back(digit_char($urandom_range(0, (b > 36 ? 36 : b) - 1)));
      txt.push_back(pick_stop());
      if (style == 1) begin
         cut = $urandom_range(1, txt.size());
         while (txt.size() > cut) void'(txt.pop_back());
      end
      foreach (txt[i]) send_char(txt[i], i == 0);
      if ($urandom_range(0, 4) == 0) send_char(8'($urandom_range(0, 255)), 1'b0);
   endtask

   task automatic test_ignored_bytes();
      send_char(8'h37, 1'b0);
      send_char(8'hFF, 1'b0);
   endtask

   // radix is still at its reset value here
   task automatic test_prefix_detect();
      send_char(CHAR_TAB, 1'b1);
      send_text("0x1fZ", 1'b0);
      send_text("0X", 1'b1);
      send_text("0x", 1'b1);
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
   endtask

   task automatic test_radix_extremes();
      write_radix(6'd1);
      send_text("01", 1'b1);
      write_radix(6'd63);
      send_text("Zz", 1'b1);
      send_char(8'h80, 1'b0);
      write_radix(6'd36);
      send_text("zZ.", 1'b1);
      write_radix(BASE_HEX);
      send_text("0xg", 1'b1);
      send_text("0 ", 1'b1);
   endtask

   task automatic test_restart_and_late_radix();
      write_radix(BASE_DEC);
      send_text("12", 1'b1);
      send_text("34;", 1'b1);
      send_text("5", 1'b1);
      // the new radix must wait for the next first byte
      write_radix(BASE_HEX);
      send_text("f;", 1'b0);
   endtask

   task automatic test_wraparound();
      write_radix(BASE_DETECT);
      send_text("0xFFFFFFFF7 ", 1'b1);
      send_text("4294967296", 1'b1);
      send_char(8'h00, 1'b0);
   endtask

   // a long run of white space before the digit keeps counting into the offset
   task automatic test_long_blank_run();
      write_radix(BASE_DEC);
      steady = 1'b1;
      send_char(CHAR_SPACE, 1'b1);
      repeat (60) send_char(pick_blank(), 1'b0);
      send_char(CHAR_ZERO + 8'd9, 1'b0);
      send_char(8'h00, 1'b0);
      steady = 1'b0;
   endtask

   task automatic test_random_strings(input logic [5:0] r, input int budget);
      int start;
      write_radix(r);
      start = bytes_sent;
      while (bytes_sent - start < budget) send_random_string();
   endtask

   task automatic test_steady_stream();
      int start;
      write_radix(BASE_DETECT);
      steady = 1'b1;
      start = bytes_sent;
      while (bytes_sent - start < 100) send_random_string();
      steady = 1'b0;
   endtask

   task automatic test_backpressure();
      write_radix(BASE_DEC);
      hold_request = 1'b1;
      repeat (12) send_random_string();
      settle();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_ignored_bytes();
      test_prefix_detect();
      test_radix_extremes();
      test_restart_and_late_radix();
      test_wraparound();
      test_long_blank_run();
      test_random_strings(BASE_DETECT, 120);
      test_random_strings(BASE_DEC, 100);
      test_random_strings(BASE_HEX, 120);
      test_random_strings(BASE_OCT, 100);
      test_random_strings(6'd2, 100);
      test_random_strings(6'd1, 70);
      test_random_strings(6'd36, 100);
      test_random_strings(6'd63, 90);
      test_random_strings(6'($urandom_range(37, 62)), 80);
      test_random_strings(6'($urandom_range(3, 35)), 100);
      test_steady_stream();
      test_backpressure();
      test_random_strings(BASE_DETECT, 90);
      settle();
      $display("sent %0d bytes under %0d radix settings, checked %0d parsed numbers",
               bytes_sent, radix_writes, numbers_seen);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("status: fail");
      end
      $finish;
   end

endmodule
